### hw/rtl/fcb_pkg.sv
package fcb_pkg;

    // Width of the modular millisecond timer.
    localparam int TimeBits = 48;

    // Failure count saturates at this value.
    localparam logic [15:0] CountMax = 16'hFFFF;

    // Successes in a row while half-open that close the breaker.
    localparam logic [1:0] HalfOpenCloseRun = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [15:0] FailureLimitReset = 16'd5;
    localparam logic [31:0] RecoveryTimeReset = 32'd30000;

    // Register indexes on the configuration port, taken from paddr[2].
    localparam logic RegFailureLimit = 1'b0;
    localparam logic RegRecoveryTime = 1'b1;

    // Depth of the queue between the front and back parts.
    localparam int QueueDepth   = 2;
    localparam int QueuePtrBits = 1;
    localparam int QueueCntBits = 2;

    // Event kinds as carried on the input tuser field.
    typedef enum logic [1:0] {
        CMD_QUERY   = 2'd0,
        CMD_SUCCESS = 2'd1,
        CMD_FAILURE = 2'd2,
        CMD_CLEAR   = 2'd3
    } cmd_t;

    // Breaker states as reported on the result channel.
    typedef enum logic [1:0] {
        MODE_CLOSED = 2'd0,
        MODE_OPEN   = 2'd1,
        MODE_HALF   = 2'd2
    } mode_t;

    // One classified event, as it travels from front to back.
    typedef struct packed {
        cmd_t                kind;
        logic [TimeBits-1:0] now;
    } op_t;

    // Configuration values seen by the back part.
    typedef struct packed {
        logic [15:0] failure_limit;
        logic [31:0] recovery_time;
    } cfg_t;

endpackage

### hw/rtl/fcb_front.sv
module fcb_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [1:0]       in_cmd,
    input  logic [47:0]      in_now,
    output logic             out_valid,
    input  logic             out_ready,
    output fcb_pkg::op_t     out_op
);

    logic         valid_reg;
    logic         valid_next;
    fcb_pkg::op_t op_reg;
    fcb_pkg::op_t op_next;
    fcb_pkg::cmd_t kind;

    // Classify the event kind; every 2-bit code names a kind.
    always_comb begin
        kind = fcb_pkg::cmd_t'(in_cmd);
    end

    // The input stage takes a new item whenever its content moves on.
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_op    = op_reg;

    always_comb begin
        valid_next = valid_reg;
        op_next    = op_reg;
        if (in_ready) begin
            valid_next = in_valid;
            if (in_valid) begin
                op_next.kind = kind;
                op_next.now  = in_now[fcb_pkg::TimeBits-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        op_reg <= op_next;
    end

endmodule

### hw/rtl/fcb_queue.sv
module fcb_queue (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push_valid,
    output logic         push_ready,
    input  fcb_pkg::op_t push_op,
    output logic         pop_valid,
    input  logic         pop_ready,
    output fcb_pkg::op_t pop_op
);

    fcb_pkg::op_t mem [fcb_pkg::QueueDepth];

    logic [fcb_pkg::QueuePtrBits-1:0] wr_ptr_reg;
    logic [fcb_pkg::QueuePtrBits-1:0] wr_ptr_next;
    logic [fcb_pkg::QueuePtrBits-1:0] rd_ptr_reg;
    logic [fcb_pkg::QueuePtrBits-1:0] rd_ptr_next;
    logic [fcb_pkg::QueueCntBits-1:0] count_reg;
    logic [fcb_pkg::QueueCntBits-1:0] count_next;
    logic                             push;
    logic                             pop;

    assign push_ready = count_reg != fcb_pkg::QueueCntBits'(fcb_pkg::QueueDepth);
    assign pop_valid  = count_reg != '0;
    assign pop_op     = mem[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_op;
        end
    end

    // The fill count never passes the depth.
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= fcb_pkg::QueueCntBits'(fcb_pkg::QueueDepth))
        else $error("queue count above depth");

endmodule

### hw/rtl/fcb_back.sv
module fcb_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  fcb_pkg::cfg_t cfg,
    input  logic          op_valid,
    output logic          op_ready,
    input  fcb_pkg::op_t  op,
    output logic          res_valid,
    input  logic          res_ready,
    output logic [1:0]    res_state,
    output logic          res_allowed
);

    fcb_pkg::mode_t                mode_reg;
    fcb_pkg::mode_t                mode_next;
    logic [15:0]                   count_reg;
    logic [15:0]                   count_next;
    logic [1:0]                    run_reg;
    logic [1:0]                    run_next;
    logic [fcb_pkg::TimeBits-1:0]  last_reg;
    logic [fcb_pkg::TimeBits-1:0]  last_next;
    logic                          res_valid_reg;
    logic                          res_valid_next;
    logic [1:0]                    res_state_reg;
    logic [1:0]                    res_state_next;
    logic                          res_allowed_reg;
    logic                          res_allowed_next;
    logic                          take;
    logic [fcb_pkg::TimeBits-1:0]  elapsed;
    logic [15:0]                   count_inc;
    logic [1:0]                    run_inc;

    // An item is carried out when the result register is free or draining.
    assign op_ready    = !res_valid_reg || res_ready;
    assign take        = op_valid && op_ready;
    assign res_valid   = res_valid_reg;
    assign res_state   = res_state_reg;
    assign res_allowed = res_allowed_reg;

    assign elapsed   = op.now - last_reg;
    assign count_inc = (count_reg == fcb_pkg::CountMax) ? count_reg : count_reg + 16'd1;
    assign run_inc   = run_reg + 2'd1;

    // Breaker state update for one event.
    always_comb begin
        mode_next  = mode_reg;
        count_next = count_reg;
        run_next   = run_reg;
        last_next  = last_reg;
        if (take) begin
            case (op.kind)
                fcb_pkg::CMD_QUERY: begin
                    if (mode_reg == fcb_pkg::MODE_OPEN &&
                        elapsed >= fcb_pkg::TimeBits'(cfg.recovery_time)) begin
                        mode_next = fcb_pkg::MODE_HALF;
                    end
                end
                fcb_pkg::CMD_SUCCESS: begin
                    if (mode_reg == fcb_pkg::MODE_HALF) begin
                        run_next = run_inc;
                        if (run_inc >= fcb_pkg::HalfOpenCloseRun) begin
                            mode_next  = fcb_pkg::MODE_CLOSED;
                            count_next = '0;
                            run_next   = '0;
                        end
                    end else if (count_reg != '0) begin
                        count_next = count_reg - 16'd1;
                    end
                end
                fcb_pkg::CMD_FAILURE: begin
                    count_next = count_inc;
                    last_next  = op.now;
                    run_next   = '0;
                    if (count_inc >= cfg.failure_limit) begin
                        mode_next = fcb_pkg::MODE_OPEN;
                    end
                end
                default: begin
                    mode_next  = fcb_pkg::MODE_CLOSED;
                    count_next = '0;
                    run_next   = '0;
                    last_next  = '0;
                end
            endcase
        end
    end

    // Result register, loaded with the state after the event.
    always_comb begin
        res_valid_next   = res_valid_reg;
        res_state_next   = res_state_reg;
        res_allowed_next = res_allowed_reg;
        if (op_ready) begin
            res_valid_next = op_valid;
            if (op_valid) begin
                res_state_next   = mode_next;
                res_allowed_next = mode_next != fcb_pkg::MODE_OPEN;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= fcb_pkg::MODE_CLOSED;
            count_reg     <= '0;
            run_reg       <= '0;
            last_reg      <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            mode_reg      <= mode_next;
            count_reg     <= count_next;
            run_reg       <= run_next;
            last_reg      <= last_next;
            res_valid_reg <= res_valid_next;
        end
        res_state_reg   <= res_state_next;
        res_allowed_reg <= res_allowed_next;
    end

    // The half-open success run closes before it can reach three.
    assert property (@(posedge aclk) disable iff (!aresetn)
        run_reg != fcb_pkg::HalfOpenCloseRun)
        else $error("success run reached close value");

    // A clear event leaves the breaker closed with both counts at zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        take && op.kind == fcb_pkg::CMD_CLEAR |=>
        mode_reg == fcb_pkg::MODE_CLOSED && count_reg == '0 && run_reg == '0)
        else $error("clear did not reset breaker");

    // A failure that reaches the limit opens the breaker and reports it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        take && op.kind == fcb_pkg::CMD_FAILURE && count_inc >= cfg.failure_limit |=>
        mode_reg == fcb_pkg::MODE_OPEN && res_valid_reg && !res_allowed_reg)
        else $error("failure at limit did not open breaker");

endmodule

### hw/rtl/fault_circuit_breaker_top.sv
// Three-state fault circuit breaker (closed, open, half-open). Each input item
// is one event (tuser: 0 query, 1 success, 2 failure, 3 clear) with a
// millisecond timestamp in tdata; each event gives exactly one result item
// with the state after the event and whether calls are allowed. The block
// takes one item per clock cycle while the result channel is not stalled:
// the event is classified in an input register, passes a two-entry queue
// and is carried out by the state update into a result register. The
// limit on that rate is the one state update per cycle, whose path holds
// a 48-bit subtract and compare against the recovery time. The two
// configuration registers sit at byte addresses 0 (failure limit) and 4
// (recovery time in ms); address bits below bit 2 are ignored, pready is
// always high, and writes are meant for times when no event is in flight.
module fault_circuit_breaker_top (
    input  logic        aclk,
    input  logic        aresetn,
    // Input channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [47:0] now_time
    input  logic [1:0]  s_tuser,   // [1:0] cmd
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [1:0] breaker_state, [2] allowed, [7:3] zero
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0]   failure_limit_reg;
    logic [15:0]   failure_limit_next;
    logic [31:0]   recovery_time_reg;
    logic [31:0]   recovery_time_next;
    logic          cfg_write;
    fcb_pkg::cfg_t cfg;

    logic          front_valid;
    logic          front_ready;
    fcb_pkg::op_t  front_op;
    logic          queue_valid;
    logic          queue_ready;
    fcb_pkg::op_t  queue_op;
    logic [1:0]    res_state;
    logic          res_allowed;

    // Configuration registers.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        failure_limit_next = failure_limit_reg;
        recovery_time_next = recovery_time_reg;
        if (cfg_write) begin
            case (paddr[2])
                fcb_pkg::RegFailureLimit: failure_limit_next = pwdata[15:0];
                fcb_pkg::RegRecoveryTime: recovery_time_next = pwdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            failure_limit_reg <= fcb_pkg::FailureLimitReset;
            recovery_time_reg <= fcb_pkg::RecoveryTimeReset;
        end else begin
            failure_limit_reg <= failure_limit_next;
            recovery_time_reg <= recovery_time_next;
        end
    end

    // Register read-back.
    always_comb begin
        case (paddr[2])
            fcb_pkg::RegFailureLimit: prdata = {16'd0, failure_limit_reg};
            fcb_pkg::RegRecoveryTime: prdata = recovery_time_reg;
            default:                  prdata = '0;
        endcase
    end

    assign cfg.failure_limit = failure_limit_reg;
    assign cfg.recovery_time = recovery_time_reg;

    fcb_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (s_tuser),
        .in_now    (s_tdata),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .out_op    (front_op)
    );

    fcb_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_op    (front_op),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready),
        .pop_op     (queue_op)
    );

    fcb_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .op_valid    (queue_valid),
        .op_ready    (queue_ready),
        .op          (queue_op),
        .res_valid   (m_tvalid),
        .res_ready   (m_tready),
        .res_state   (res_state),
        .res_allowed (res_allowed)
    );

    assign m_tdata = {5'd0, res_allowed, res_state};

endmodule
